// ===== rtl/core/tme_pkg.sv =====
`timescale 1ns / 1ps
package tme_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned StampW = 48;
  localparam int unsigned Q16W = 17;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumLanes = 3;
  localparam logic [Q16W-1:0] OneQ16 = 17'd65536;
  localparam logic [19:0] UsPerS = 20'd1000000;

  localparam logic [Q16W-1:0] AlphaReset = 17'd26214;
  localparam logic [31:0] MaxGapReset = 32'd500000;
  localparam logic [31:0] TimeoutReset = 32'd500;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_SCORE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_ENABLE  = 3'd0,
    CFG_ALPHA   = 3'd1,
    CFG_MAX_GAP = 3'd2,
    CFG_TIMEOUT = 3'd3,
    CFG_DEF_CONF = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEL_DIV,
    ST_VEL_EMA,
    ST_ACC_DIV,
    ST_ACC_EMA,
    ST_DONE
  } est_state_t;

  // Command from the sequencer to every lane.
  typedef struct packed {
    logic start;
    logic acc_phase;
    logic ema;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
  } lane_stat_t;

  function automatic logic [Q16W-1:0] cap_q16(input logic [Q16W-1:0] v);
    cap_q16 = (v > OneQ16) ? OneQ16 : v;
  endfunction

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/core/tme_if.sv =====
`timescale 1ns / 1ps
interface tme_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [31:0] pos_forward;
  logic signed [31:0] pos_left;
  logic signed [31:0] pos_up;
  logic [47:0] sample_stamp_us;
  logic [16:0] score;
  logic last_hypothesis;
  modport source(output valid, kind, pos_forward, pos_left, pos_up, sample_stamp_us,
                 score, last_hypothesis, input ready);
  modport sink(input valid, kind, pos_forward, pos_left, pos_up, sample_stamp_us,
               score, last_hypothesis, output ready);
endinterface

interface tme_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] right_pos;
  logic signed [31:0] up_pos;
  logic signed [31:0] fwd_pos;
  logic signed [31:0] right_vel;
  logic signed [31:0] up_vel;
  logic signed [31:0] fwd_vel;
  logic signed [31:0] right_acc;
  logic signed [31:0] up_acc;
  logic signed [31:0] fwd_acc;
  logic [16:0] confidence;
  logic target_lost;
  logic [47:0] result_stamp_us;
  modport source(output valid, right_pos, up_pos, fwd_pos, right_vel, up_vel, fwd_vel,
                 right_acc, up_acc, fwd_acc, confidence, target_lost, result_stamp_us,
                 input ready);
  modport sink(input valid, right_pos, up_pos, fwd_pos, right_vel, up_vel, fwd_vel,
               right_acc, up_acc, fwd_acc, confidence, target_lost, result_stamp_us,
               output ready);
endinterface

// ===== rtl/core/tme_lane.sv =====
`timescale 1ns / 1ps
// One axis: signed difference scaled by 1e6, divided by the gap one quotient bit per
// cycle (restoring), saturated, then blended with the previous estimate.
module tme_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tme_pkg::lane_cmd_t        cmd,
  input  logic signed [31:0]        cur_val,
  input  logic signed [31:0]        prev_val,
  input  logic signed [31:0]        prev_est,
  input  logic [31:0]               gap,
  input  logic [16:0]               alpha,
  output tme_pkg::lane_stat_t       stat,
  output logic signed [31:0]        est_out
);
  localparam int unsigned NumW = 53;
  localparam int unsigned CntW = 6;

  logic [NumW-1:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic signed [31:0] raw_r, raw_nxt;
  logic signed [31:0] est_r, est_nxt;

  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [52:0] prod;
  logic [33:0] trial;
  logic [33:0] shifted;
  logic signed [63:0] qs;
  logic signed [50:0] blend;
  logic signed [50:0] blend_adj;

  always_comb begin
    diff = 33'(signed'(cur_val)) - 33'(signed'(prev_val));
    mag = diff[32] ? 33'(-diff) : diff;
    prod = 53'(mag) * 53'(tme_pkg::UsPerS);
    shifted = {rem_r, num_r[NumW-1]};
    trial = shifted - {2'b0, gap};
    qs = neg_r ? -64'(num_r) : 64'(num_r);
    blend = 51'(signed'({1'b0, alpha})) * 51'(raw_r)
          + 51'(signed'({1'b0, tme_pkg::OneQ16 - alpha})) * 51'(prev_est);
    blend_adj = blend + ((blend < 0) ? 51'sd65535 : 51'sd0);

    num_nxt = num_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    raw_nxt = raw_r;
    est_nxt = est_r;
    if (cmd.start) begin
      num_nxt = prod;
      rem_nxt = '0;
      neg_nxt = diff[32];
      cnt_nxt = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        num_nxt = {num_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[32:0];
        num_nxt = {num_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
      if (cnt_r == CntW'(0)) begin
        busy_nxt = 1'b0;
      end
    end else if (cmd.ema) begin
      est_nxt = blend_adj[47:16];
    end
    if (!busy_r && !cmd.start && !cmd.ema && cnt_r == CntW'(0)) begin
      raw_nxt = raw_r;
    end
    if (busy_r && cnt_r == CntW'(1)) begin
      raw_nxt = raw_r;
    end
    if (!busy_r && !cmd.start && !cmd.ema) begin
      raw_nxt = tme_pkg::sat32(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    raw_r <= raw_nxt;
    est_r <= est_nxt;
  end

  assign stat.busy = busy_r;
  assign est_out = est_r;
endmodule

// ===== rtl/core/target_motion_estimator.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake       | Contents
// in       | in  | in_valid/ready  | kind, point, stamp, score, last_hypothesis
// out      | out | out_valid/ready | remapped position, velocity, acceleration, status
// cfg      | in  | cfg_we          | register index and data, no read-back
//
// A point with a trusted gap runs a 53-step division per lane for velocity, then a blend, then
// the same for acceleration; the result register loads once the output is free, and no beat
// is taken until the sequencer is idle again. Other points, scores and ticks need no lanes;
// the next beat can follow while the output is free. Three axis lanes run in parallel and the
// result register merges them. Reset is synchronous and active low and restores control and
// tracking state, not data registers. A waiting result blocks input only while unaccepted.
module target_motion_estimator (
  input  logic              clk,
  input  logic              rst_n,
  tme_in_if.sink            in_ch,
  tme_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_data
);
  logic        en_r;
  logic [16:0] alpha_r, defc_r;
  logic [31:0] gap_max_r, timeout_r;

  logic        have_prev_r, active_r, have_conf_r;
  logic [16:0] conf_r, maxs_r;
  logic [31:0] idle_r;
  logic signed [31:0] ppos_r [3];
  logic signed [31:0] pvel_r [3];
  logic signed [31:0] pacc_r [3];
  logic signed [31:0] cpos_r [3];
  logic [47:0] pstamp_r, cstamp_r;
  logic [31:0] gap_r;

  tme_pkg::est_state_t st_r, st_nxt;
  tme_pkg::lane_cmd_t cmd;
  tme_pkg::lane_stat_t lstat [3];
  logic signed [31:0] lest [3];
  logic signed [31:0] lcur [3];
  logic signed [31:0] lprv [3];
  logic signed [31:0] lpest [3];
  logic [2:0] wait_r;

  logic out_valid_r;
  logic signed [31:0] o_pos_r [3];
  logic signed [31:0] o_vel_r [3];
  logic signed [31:0] o_acc_r [3];
  logic [16:0] o_conf_r;
  logic o_lost_r;
  logic [47:0] o_stamp_r;

  logic in_fire, out_free;
  logic signed [31:0] npos [3];
  logic signed [48:0] dt;
  logic trusted;
  logic [31:0] idle_inc;
  logic [16:0] s_cap, new_max;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == tme_pkg::ST_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    npos[0] = (in_ch.pos_left == 32'sh80000000) ? 32'sh7fffffff : -in_ch.pos_left;
    npos[1] = in_ch.pos_up;
    npos[2] = in_ch.pos_forward;
    dt = 49'(in_ch.sample_stamp_us) - 49'(pstamp_r);
    trusted = en_r && have_prev_r && (dt > 0) && (dt <= 49'(gap_max_r));
    idle_inc = (idle_r == 32'hffffffff) ? idle_r : idle_r + 32'd1;
    s_cap = tme_pkg::cap_q16(in_ch.score);
    new_max = (s_cap > maxs_r) ? s_cap : maxs_r;
  end

  // Lane operands switch from position to velocity in the acceleration phase.
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      assign lcur[g] = cmd.acc_phase ? lest[g] : cpos_r[g];
      assign lprv[g] = cmd.acc_phase ? pvel_r[g] : ppos_r[g];
      assign lpest[g] = cmd.acc_phase ? pacc_r[g] : pvel_r[g];
      tme_lane u_lane (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cur_val(lcur[g]), .prev_val(lprv[g]), .prev_est(lpest[g]),
        .gap(gap_r), .alpha(tme_pkg::cap_q16(alpha_r)),
        .stat(lstat[g]), .est_out(lest[g])
      );
    end
  endgenerate

  logic signed [31:0] vel_hold_r [3];

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    case (st_r)
      tme_pkg::ST_IDLE: begin
        if (in_fire && in_ch.kind == tme_pkg::KIND_POINT && trusted) begin
          st_nxt = tme_pkg::ST_VEL_DIV;
        end
      end
      tme_pkg::ST_VEL_DIV: begin
        if (wait_r == 3'd0) cmd.start = 1'b1;
        else if (wait_r == 3'd2 && !lstat[0].busy) st_nxt = tme_pkg::ST_VEL_EMA;
      end
      tme_pkg::ST_VEL_EMA: begin
        if (wait_r == 3'd0) cmd.ema = 1'b1;
        else st_nxt = tme_pkg::ST_ACC_DIV;
      end
      tme_pkg::ST_ACC_DIV: begin
        cmd.acc_phase = 1'b1;
        if (wait_r == 3'd0) cmd.start = 1'b1;
        else if (wait_r == 3'd2 && !lstat[0].busy) st_nxt = tme_pkg::ST_ACC_EMA;
      end
      tme_pkg::ST_ACC_EMA: begin
        cmd.acc_phase = 1'b1;
        if (wait_r == 3'd0) cmd.ema = 1'b1;
        else st_nxt = tme_pkg::ST_DONE;
      end
      tme_pkg::ST_DONE: begin
        if (out_free) st_nxt = tme_pkg::ST_IDLE;
      end
      default: st_nxt = tme_pkg::ST_IDLE;
    endcase
  end

  // wait_r: 0 = issue, 1 = settle / wait out busy, 3 = raw latched, 2 = watch busy and move on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tme_pkg::ST_IDLE;
      wait_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r) wait_r <= 3'd0;
      else if (wait_r == 3'd0) wait_r <= 3'd1;
      else if (wait_r == 3'd1 && (st_r == tme_pkg::ST_VEL_DIV || st_r == tme_pkg::ST_ACC_DIV))
        wait_r <= lstat[0].busy ? 3'd1 : 3'd3;
      else if (wait_r == 3'd3) wait_r <= 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      alpha_r <= tme_pkg::AlphaReset;
      gap_max_r <= tme_pkg::MaxGapReset;
      timeout_r <= tme_pkg::TimeoutReset;
      defc_r <= tme_pkg::OneQ16;
      have_prev_r <= 1'b0;
      active_r <= 1'b0;
      have_conf_r <= 1'b0;
      conf_r <= tme_pkg::OneQ16;
      maxs_r <= '0;
      idle_r <= '0;
      pstamp_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ppos_r[i] <= '0;
        pvel_r[i] <= '0;
        pacc_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          tme_pkg::CFG_ENABLE:   en_r <= cfg_data[0];
          tme_pkg::CFG_ALPHA:    alpha_r <= cfg_data[16:0];
          tme_pkg::CFG_MAX_GAP:  gap_max_r <= cfg_data;
          tme_pkg::CFG_TIMEOUT:  timeout_r <= cfg_data;
          tme_pkg::CFG_DEF_CONF: defc_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (in_fire) begin
        case (in_ch.kind)
          tme_pkg::KIND_POINT: begin
            pstamp_r <= in_ch.sample_stamp_us;
            have_prev_r <= 1'b1;
            active_r <= 1'b1;
            idle_r <= '0;
            if (!trusted) begin
              out_valid_r <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                ppos_r[i] <= npos[i];
                pvel_r[i] <= '0;
                pacc_r[i] <= '0;
              end
            end
          end
          tme_pkg::KIND_SCORE: begin
            maxs_r <= new_max;
            if (in_ch.last_hypothesis) begin
              maxs_r <= '0;
              if (new_max != 17'd0) begin
                conf_r <= new_max;
                have_conf_r <= 1'b1;
              end
            end
          end
          tme_pkg::KIND_TICK: begin
            if (active_r) begin
              idle_r <= idle_inc;
              if (idle_inc > timeout_r) begin
                active_r <= 1'b0;
                have_prev_r <= 1'b0;
                out_valid_r <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (st_r == tme_pkg::ST_VEL_EMA && wait_r == 3'd1) begin
        for (int i = 0; i < 3; i++) vel_hold_r[i] <= lest[i];
      end
      if (st_r == tme_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          ppos_r[i] <= cpos_r[i];
          pvel_r[i] <= vel_hold_r[i];
          pacc_r[i] <= lest[i];
        end
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == tme_pkg::KIND_POINT) begin
      gap_r <= dt[31:0];
      cstamp_r <= in_ch.sample_stamp_us;
      for (int i = 0; i < 3; i++) cpos_r[i] <= npos[i];
    end
    if (in_fire && in_ch.kind == tme_pkg::KIND_POINT && !trusted) begin
      for (int i = 0; i < 3; i++) begin
        o_pos_r[i] <= npos[i];
        o_vel_r[i] <= '0;
        o_acc_r[i] <= '0;
      end
      o_conf_r <= have_conf_r ? conf_r : tme_pkg::cap_q16(defc_r);
      o_lost_r <= 1'b0;
      o_stamp_r <= in_ch.sample_stamp_us;
    end else if (in_fire && in_ch.kind == tme_pkg::KIND_TICK) begin
      for (int i = 0; i < 3; i++) begin
        o_pos_r[i] <= '0;
        o_vel_r[i] <= '0;
        o_acc_r[i] <= '0;
      end
      o_conf_r <= '0;
      o_lost_r <= 1'b1;
      o_stamp_r <= '0;
    end else if (st_r == tme_pkg::ST_DONE && out_free) begin
      for (int i = 0; i < 3; i++) begin
        o_pos_r[i] <= cpos_r[i];
        o_vel_r[i] <= vel_hold_r[i];
        o_acc_r[i] <= lest[i];
      end
      o_conf_r <= have_conf_r ? conf_r : tme_pkg::cap_q16(defc_r);
      o_lost_r <= 1'b0;
      o_stamp_r <= cstamp_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.right_pos = o_pos_r[0];
  assign out_ch.up_pos = o_pos_r[1];
  assign out_ch.fwd_pos = o_pos_r[2];
  assign out_ch.right_vel = o_vel_r[0];
  assign out_ch.up_vel = o_vel_r[1];
  assign out_ch.fwd_vel = o_vel_r[2];
  assign out_ch.right_acc = o_acc_r[0];
  assign out_ch.up_acc = o_acc_r[1];
  assign out_ch.fwd_acc = o_acc_r[2];
  assign out_ch.confidence = o_conf_r;
  assign out_ch.target_lost = o_lost_r;
  assign out_ch.result_stamp_us = o_stamp_r;

`ifndef SYNTH
  a_lost_zero_conf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_lost_r |-> o_conf_r == 17'd0 && o_stamp_r == 48'd0)
    else $error("lost result with nonzero fields");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != tme_pkg::ST_IDLE |-> !in_ch.ready)
    else $error("input accepted during estimate");
  a_conf_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_conf_r <= tme_pkg::OneQ16)
    else $error("confidence above one");
`endif
endmodule

// ===== bench/target_motion_estimator_tb.sv =====
`timescale 1ns / 1ps
// Bench for the target motion estimator. Points, scores and ticks are pushed
// through the input channel under several register settings and idling
// patterns, and every result beat is compared with a behavioral predictor or a directed track.
module target_motion_estimator_tb;

  localparam int unsigned CycleLimit = 3000000;
  // Settle well past the longest point.
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned HoldOffCycles = 3000;

  // One input beat.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] fwd;
    logic signed [31:0] left;
    logic signed [31:0] up;
    logic [47:0]        stamp;
    logic [16:0]        score;
    logic               last;
  } sample_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] right_pos;
    logic signed [31:0] up_pos;
    logic signed [31:0] fwd_pos;
    logic signed [31:0] right_vel;
    logic signed [31:0] up_vel;
    logic signed [31:0] fwd_vel;
    logic signed [31:0] right_acc;
    logic signed [31:0] up_acc;
    logic signed [31:0] fwd_acc;
    logic [16:0]        confidence;
    logic               lost;
    logic [47:0]        stamp;
  } track_t;

  // A directed row either carries its expected track or leaves it to the predictor.
  typedef struct packed {
    sample_t s;
    logic    typed;
    track_t  r;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  tme_in_if  in_ch ();
  tme_out_if out_ch ();

  target_motion_estimator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor copy of the registers.
  logic        est_en;
  logic [16:0] est_alpha;
  logic [31:0] est_max_gap;
  logic [31:0] est_timeout;
  logic [16:0] est_def_conf;

  // Predictor copy of the tracking state.
  logic        trk_have_prev;
  longint      trk_pos [3];
  longint      trk_vel [3];
  longint      trk_acc [3];
  logic [47:0] trk_stamp;
  logic [16:0] trk_conf;
  logic        trk_have_conf;
  logic [16:0] trk_max_score;
  logic        trk_active;
  logic [31:0] trk_idle;

  track_t expected_tracks [$];
  int unsigned mismatches;
  int unsigned cycles;

  // Idling controls, in percent of cycles.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left;

  function automatic logic [16:0] clamp_unit(input logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(input longint a, input longint raw, input longint old);
    return (a * raw + (64'sd65536 - a) * old) / 64'sd65536;
  endfunction

  // Advances the tracking state by one input beat; returns 1 when a track beat follows.
  function automatic bit predict_track(input sample_t s, output track_t r);
    longint p [3];
    longint v [3];
    longint a [3];
    longint dt;
    longint alpha;
    longint raw;
    r = '0;
    case (s.kind)
      tme_pkg::KIND_POINT: begin
        dt = longint'({16'd0, s.stamp}) - longint'({16'd0, trk_stamp});
        alpha = longint'({47'd0, clamp_unit(est_alpha)});
        p[0] = clamp_s32(-longint'(s.left));
        p[1] = longint'(s.up);
        p[2] = longint'(s.fwd);
        for (int i = 0; i < 3; i++) begin
          v[i] = 0;
          a[i] = 0;
        end
        if (est_en && trk_have_prev && dt > 0 && dt <= longint'({32'd0, est_max_gap})) begin
          for (int i = 0; i < 3; i++) begin
            raw = clamp_s32((p[i] - trk_pos[i]) * 64'sd1000000 / dt);
            v[i] = blend(alpha, raw, trk_vel[i]);
            raw = clamp_s32((v[i] - trk_vel[i]) * 64'sd1000000 / dt);
            a[i] = blend(alpha, raw, trk_acc[i]);
          end
        end
        for (int i = 0; i < 3; i++) begin
          trk_pos[i] = p[i];
          trk_vel[i] = v[i];
          trk_acc[i] = a[i];
        end
        trk_stamp = s.stamp;
        trk_have_prev = 1'b1;
        trk_active = 1'b1;
        trk_idle = '0;
        r.right_pos = p[0][31:0];
        r.up_pos = p[1][31:0];
        r.fwd_pos = p[2][31:0];
        r.right_vel = v[0][31:0];
        r.up_vel = v[1][31:0];
        r.fwd_vel = v[2][31:0];
        r.right_acc = a[0][31:0];
        r.up_acc = a[1][31:0];
        r.fwd_acc = a[2][31:0];
        r.confidence = trk_have_conf ? trk_conf : clamp_unit(est_def_conf);
        r.stamp = s.stamp;
        return 1'b1;
      end
      tme_pkg::KIND_SCORE: begin
        if (clamp_unit(s.score) > trk_max_score) trk_max_score = clamp_unit(s.score);
        if (s.last) begin
          if (trk_max_score != 0) begin
            trk_conf = trk_max_score;
            trk_have_conf = 1'b1;
          end
          trk_max_score = '0;
        end
        return 1'b0;
      end
      tme_pkg::KIND_TICK: begin
        if (!trk_active) return 1'b0;
        if (trk_idle != 32'hFFFF_FFFF) trk_idle = trk_idle + 1;
        if (trk_idle <= est_timeout) return 1'b0;
        // The target went stale: one all-zero beat flagged as lost.
        trk_active = 1'b0;
        trk_have_prev = 1'b0;
        r.lost = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic sample_t point(input logic [31:0] f, input logic [31:0] l,
                                    input logic [31:0] u, input logic [47:0] st);
    sample_t s;
    s = '0;
    s.kind = tme_pkg::KIND_POINT;
    s.fwd = f;
    s.left = l;
    s.up = u;
    s.stamp = st;
    return s;
  endfunction

  function automatic sample_t hypothesis(input logic [16:0] sc, input logic lst);
    sample_t s;
    s = '0;
    s.kind = tme_pkg::KIND_SCORE;
    s.score = sc;
    s.last = lst;
    return s;
  endfunction

  function automatic sample_t other(input logic [1:0] k);
    sample_t s;
    s = '1;
    s.kind = k;
    return s;
  endfunction

  // A point track with zero motion, as read straight off the remap.
  function automatic track_t still(input logic [31:0] r, input logic [31:0] u,
                                   input logic [31:0] f, input logic [47:0] st);
    track_t t;
    t = '0;
    t.right_pos = r;
    t.up_pos = u;
    t.fwd_pos = f;
    t.confidence = 17'd65536;
    t.stamp = st;
    return t;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
    mismatches++;
  endtask

  // Receiver: random stalls, an optional long hold-off, and the track check.
  always @(posedge clk) begin
    track_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tracks.size() == 0) begin
          report_mismatch("unexpected track beat", 64'd1, 64'd0);
        end else begin
          want = expected_tracks.pop_front();
          if (out_ch.right_pos !== want.right_pos)
            report_mismatch("right_pos", 64'(out_ch.right_pos), 64'(want.right_pos));
          if (out_ch.up_pos !== want.up_pos)
            report_mismatch("up_pos", 64'(out_ch.up_pos), 64'(want.up_pos));
          if (out_ch.fwd_pos !== want.fwd_pos)
            report_mismatch("fwd_pos", 64'(out_ch.fwd_pos), 64'(want.fwd_pos));
          if (out_ch.right_vel !== want.right_vel)
            report_mismatch("right_vel", 64'(out_ch.right_vel), 64'(want.right_vel));
          if (out_ch.up_vel !== want.up_vel)
            report_mismatch("up_vel", 64'(out_ch.up_vel), 64'(want.up_vel));
          if (out_ch.fwd_vel !== want.fwd_vel)
            report_mismatch("fwd_vel", 64'(out_ch.fwd_vel), 64'(want.fwd_vel));
          if (out_ch.right_acc !== want.right_acc)
            report_mismatch("right_acc", 64'(out_ch.right_acc), 64'(want.right_acc));
          if (out_ch.up_acc !== want.up_acc)
            report_mismatch("up_acc", 64'(out_ch.up_acc), 64'(want.up_acc));
          if (out_ch.fwd_acc !== want.fwd_acc)
            report_mismatch("fwd_acc", 64'(out_ch.fwd_acc), 64'(want.fwd_acc));
          if (out_ch.confidence !== want.confidence)
            report_mismatch("confidence", 64'(out_ch.confidence), 64'(want.confidence));
          if (out_ch.target_lost !== want.lost)
            report_mismatch("target_lost", 64'(out_ch.target_lost), 64'(want.lost));
          if (out_ch.result_stamp_us !== want.stamp)
            report_mismatch("result_stamp_us", 64'(out_ch.result_stamp_us), 64'(want.stamp));
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one beat and returns at the edge where it is taken. Valid stays high
  // into the next call unless that call idles first.
  task automatic send_sample(input sample_t s, input logic typed, input track_t typed_r);
    track_t r;
    bit has_r;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= s.kind;
    in_ch.pos_forward <= s.fwd;
    in_ch.pos_left <= s.left;
    in_ch.pos_up <= s.up;
    in_ch.sample_stamp_us <= s.stamp;
    in_ch.score <= s.score;
    in_ch.last_hypothesis <= s.last;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    has_r = predict_track(s, r);
    if (has_r) expected_tracks.push_back(typed ? typed_r : r);
  endtask

  // Waits until every expected track has come, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_tracks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input tme_pkg::cfg_idx_t idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      tme_pkg::CFG_ENABLE:   est_en = data[0];
      tme_pkg::CFG_ALPHA:    est_alpha = data[16:0];
      tme_pkg::CFG_MAX_GAP:  est_max_gap = data;
      tme_pkg::CFG_TIMEOUT:  est_timeout = data;
      tme_pkg::CFG_DEF_CONF: est_def_conf = data[16:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic en, input logic [31:0] alpha, input logic [31:0] gap,
                           input logic [31:0] tmo, input logic [31:0] conf);
    write_reg(tme_pkg::CFG_ENABLE, {31'd0, en});
    write_reg(tme_pkg::CFG_ALPHA, alpha);
    write_reg(tme_pkg::CFG_MAX_GAP, gap);
    write_reg(tme_pkg::CFG_TIMEOUT, tmo);
    write_reg(tme_pkg::CFG_DEF_CONF, conf);
    cfg_we <= 1'b0;
  endtask

  // Random walk of the stimulus, so most points give trusted gaps.
  logic [31:0] walk [3];
  logic [47:0] walk_stamp;

  function automatic logic [31:0] step_coord(input logic [31:0] c);
    if ($urandom_range(9) == 0) return $urandom;
    return c + $urandom_range(1 << 20) - (1 << 19);
  endfunction

  function automatic sample_t random_sample(input bit no_scores);
    sample_t s;
    int unsigned pick;
    int unsigned gap_pick;
    s = '0;
    s.fwd = $urandom;
    s.left = $urandom;
    s.up = $urandom;
    s.stamp = 48'({$urandom, $urandom});
    s.score = 17'($urandom);
    s.last = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 50 || (no_scores && pick < 70)) begin
      for (int i = 0; i < 3; i++) walk[i] = step_coord(walk[i]);
      gap_pick = $urandom_range(99);
      if (gap_pick < 75) walk_stamp = walk_stamp + $urandom_range(1, 30000);
      else if (gap_pick < 88 && gap_pick >= 82) walk_stamp = walk_stamp - $urandom_range(1, 5000);
      else if (gap_pick >= 88 && gap_pick < 94)
        walk_stamp = walk_stamp + $urandom_range(400000, 600000);
      else if (gap_pick >= 94) walk_stamp = 48'({$urandom, $urandom});
      s = point(walk[2], walk[1], walk[0], walk_stamp);
    end else if (pick < 70) begin
      s.kind = tme_pkg::KIND_SCORE;
      s.last = ($urandom_range(3) == 0);
    end else if (pick < 95) begin
      s.kind = tme_pkg::KIND_TICK;
    end else begin
      s.kind = tme_pkg::KIND_NONE;
    end
    return s;
  endfunction

  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input bit no_scores);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned n = 0; n < ItemsPerPhase; n++) send_sample(random_sample(no_scores), 1'b0, '0);
    drain();
  endtask

  row_t rows [18];
  localparam int unsigned FirstScoreRow = 12;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tme_pkg::CFG_ENABLE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = tme_pkg::KIND_NONE;
    in_ch.pos_forward = '0;
    in_ch.pos_left = '0;
    in_ch.pos_up = '0;
    in_ch.sample_stamp_us = '0;
    in_ch.score = '0;
    in_ch.last_hypothesis = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = 0;
    // Predictor at its reset state.
    est_en = 1'b1;
    est_alpha = tme_pkg::AlphaReset;
    est_max_gap = tme_pkg::MaxGapReset;
    est_timeout = tme_pkg::TimeoutReset;
    est_def_conf = tme_pkg::OneQ16;
    trk_have_prev = 1'b0;
    for (int i = 0; i < 3; i++) begin
      trk_pos[i] = 0;
      trk_vel[i] = 0;
      trk_acc[i] = 0;
      walk[i] = '0;
    end
    trk_stamp = '0;
    trk_conf = tme_pkg::OneQ16;
    trk_have_conf = 1'b0;
    trk_max_score = '0;
    trk_active = 1'b0;
    trk_idle = '0;
    walk_stamp = 48'd5000000;

    // Directed rows. The first point after reset has no motion, and the most
    // negative left saturates when it is negated into the right axis.
    rows[0] = '{point(32'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 48'd1000), 1'b1,
                still(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536, 48'd1000)};
    rows[1] = '{point(32'd131072, -32'sd65536, 32'd196608, 48'd2000), 1'b0, '0};
    rows[2] = '{point(-32'sd196608, 32'd65536, 32'h7FFF_0000, 48'd4000), 1'b0, '0};
    // The largest stamp lies far beyond the trusted gap.
    rows[3] = '{point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFF), 1'b1,
                still(32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF)};
    // A stamp going backward, then a zero gap: both leave motion at zero.
    rows[4] = '{point(32'd0, 32'd0, 32'd0, 48'd0), 1'b1, still(32'd0, 32'd0, 32'd0, 48'd0)};
    rows[5] = '{point(32'd5, 32'd6, 32'd7, 48'd0), 1'b1,
                still(-32'sd6, 32'd7, 32'd5, 48'd0)};
    // A gap of exactly the limit is trusted, one past it is not.
    rows[6] = '{point(32'h0010_0000, -32'sh0010_0000, 32'h0010_0000, 48'd500000), 1'b0, '0};
    rows[7] = '{point(32'd0, 32'd0, 32'd0, 48'd1000001), 1'b1,
                still(32'd0, 32'd0, 32'd0, 48'd1000001)};
    // Full-scale jumps over one microsecond saturate the raw estimates.
    rows[8] = '{point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'd1000002), 1'b0, '0};
    rows[9] = '{point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 48'd1000003), 1'b0, '0};
    rows[10] = '{other(tme_pkg::KIND_NONE), 1'b0, '0};
    rows[11] = '{other(tme_pkg::KIND_TICK), 1'b0, '0};
    // Detections: a score above one, an all-zero detection, then a small score.
    rows[12] = '{hypothesis(17'h1FFFF, 1'b0), 1'b0, '0};
    rows[13] = '{hypothesis(17'd0, 1'b1), 1'b0, '0};
    rows[14] = '{point(32'd1, 32'd2, 32'd3, 48'd1000100), 1'b0, '0};
    rows[15] = '{hypothesis(17'd0, 1'b1), 1'b0, '0};
    rows[16] = '{hypothesis(17'd1234, 1'b1), 1'b0, '0};
    rows[17] = '{point(32'd4, 32'd5, 32'd6, 48'd1000200), 1'b0, '0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values, no idling.
    for (int unsigned k = 0; k < FirstScoreRow; k++) send_sample(rows[k].s, rows[k].typed, rows[k].r);
    drain();

    // Oversized alpha and default confidence, reported before any score is cached.
    configure(1'b1, 32'h1FFFF, 32'd500000, 32'd3, 32'h1FFFF);
    random_phase(63, 0, 1'b1);

    // Zero alpha and confidence, no gap limit, immediate timeout.
    configure(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    for (int unsigned k = FirstScoreRow; k < $size(rows); k++)
      send_sample(rows[k].s, rows[k].typed, rows[k].r);
    random_phase(0, 63, 1'b0);

    // Estimation off, zero gap limit, a timeout that can never expire.
    configure(1'b0, 32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd65536);
    random_phase(7, 7, 1'b0);

    // The receiver holds off for a long stretch so the block backs up.
    configure(1'b1, $urandom_range(65536), 32'd100000, 32'd5, $urandom_range(65536));
    rx_hold_left = HoldOffCycles;
    random_phase(0, 0, 1'b0);

    configure(1'b1, $urandom_range(65536), 32'd500000, 32'd10, 32'd40000);
    random_phase(63, 63, 1'b0);

    configure(1'b1, 32'd26214, 32'd50000, 32'd2, 32'd65536);
    random_phase(0, 0, 1'b0);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
